@@ sv/ccfp_pkg.sv @@
// ----------------------------------------------------------------------------
// ccfp_pkg
// Shared types, constants and keyword tables of the command frame parser.
// ----------------------------------------------------------------------------
package ccfp_pkg;

  // Default buffer limits
  localparam int KEY_CHARS_DEF   = 15;
  localparam int VALUE_CHARS_DEF = 31;

  // Fixed field widths of a result beat
  localparam int KEY_LEN_W  = 4;
  localparam int VAL_LEN_W  = 5;
  localparam int TEXT_W     = 8;
  localparam int M_TDATA_W  = 24;
  localparam int M_TUSER_W  = 2;

  // Field walker widths and limits
  localparam int CNT_W      = 5;
  localparam int FIELD_W    = 3;
  localparam int FIELD_MAX  = 4;
  localparam int CHAR_MAX   = 31;
  localparam int TARGET_LEN = 5;
  localparam int WORD_COUNT = 5;

  localparam logic [TEXT_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [TEXT_W-1:0] CHAR_COMMA = 8'h2C;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Field numbers of the frame
  localparam logic [FIELD_W-1:0] FLD_TARGET = 3'd0;
  localparam logic [FIELD_W-1:0] FLD_ITEM   = 3'd1;
  localparam logic [FIELD_W-1:0] FLD_KEY    = 3'd2;
  localparam logic [FIELD_W-1:0] FLD_VALUE  = 3'd3;

  typedef enum logic [2:0] {
    CMD_NO_MATCH = 3'd0,
    CMD_LED      = 3'd1,
    CMD_CAR      = 3'd2,
    CMD_SERVO    = 3'd3,
    CMD_COMPASS  = 3'd4,
    CMD_ULT      = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_KEY    = 2'd1,
    KIND_VALUE  = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    BK_HEADER,
    BK_KEY,
    BK_VALUE
  } back_state_e;

  // Keyword tables: the target word and the five item words (bit 0 = LED)
  localparam logic [TEXT_W-1:0] TARGET_WORD [TARGET_LEN] =
    '{8'h53, 8'h54, 8'h4D, 8'h33, 8'h32};

  localparam logic [TEXT_W-1:0] ITEM_WORDS [WORD_COUNT][8] = '{
    '{8'h4C, 8'h45, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h43, 8'h41, 8'h52, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h45, 8'h52, 8'h56, 8'h4F, 8'h00, 8'h00, 8'h00},
    '{8'h43, 8'h4F, 8'h4D, 8'h50, 8'h41, 8'h53, 8'h53, 8'h00},
    '{8'h55, 8'h4C, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [CNT_W-1:0] ITEM_LENS [WORD_COUNT] =
    '{5'd3, 5'd3, 5'd5, 5'd7, 5'd3};

  // One finished frame, handed from front to back
  typedef struct packed {
    logic                 bank;
    logic                 status;
    cmd_e                 code;
    logic [KEY_LEN_W-1:0] key_len;
    logic [VAL_LEN_W-1:0] val_len;
  } frame_desc_t;

  // Control part of one result beat
  typedef struct packed {
    result_kind_e         kind;
    logic                 status;
    cmd_e                 code;
    logic [KEY_LEN_W-1:0] key_len;
    logic [VAL_LEN_W-1:0] val_len;
    logic                 last;
  } out_item_t;

  // Target character at a position below the target length
  function automatic logic [TEXT_W-1:0] target_char(input logic [2:0] pos);
    logic [TEXT_W-1:0] ch;
    unique case (pos)
      3'd0:    ch = TARGET_WORD[0];
      3'd1:    ch = TARGET_WORD[1];
      3'd2:    ch = TARGET_WORD[2];
      3'd3:    ch = TARGET_WORD[3];
      3'd4:    ch = TARGET_WORD[4];
      default: ch = CHAR_NUL;
    endcase
    return ch;
  endfunction

  // Item words that carry character ch at position pos
  function automatic logic [WORD_COUNT-1:0] char_match(input logic [CNT_W-1:0] pos,
                                                       input logic [TEXT_W-1:0] ch);
    logic [WORD_COUNT-1:0] m;
    for (int w = 0; w < WORD_COUNT; w++) begin
      m[w] = (pos < ITEM_LENS[w]) && (ITEM_WORDS[w][pos[2:0]] == ch);
    end
    return m;
  endfunction

  // Item words whose length equals cnt
  function automatic logic [WORD_COUNT-1:0] len_match(input logic [CNT_W-1:0] cnt);
    logic [WORD_COUNT-1:0] m;
    for (int w = 0; w < WORD_COUNT; w++) begin
      m[w] = (cnt == ITEM_LENS[w]);
    end
    return m;
  endfunction

  // Lowest surviving keyword gives the command code
  function automatic cmd_e first_code(input logic [WORD_COUNT-1:0] mask);
    cmd_e c;
    priority if (mask[0]) c = CMD_LED;
    else if (mask[1])     c = CMD_CAR;
    else if (mask[2])     c = CMD_SERVO;
    else if (mask[3])     c = CMD_COMPASS;
    else if (mask[4])     c = CMD_ULT;
    else                  c = CMD_NO_MATCH;
    return c;
  endfunction

endpackage

@@ sv/ccfp_ram.sv @@
// ----------------------------------------------------------------------------
// ccfp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ccfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array and read register, no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ccfp_front.sv @@
// ----------------------------------------------------------------------------
// ccfp_front
// Byte walker: splits the frame at commas, matches target and item, writes
// key and value characters to the current buffer bank and posts a frame
// descriptor on the frame-end beat.
// ----------------------------------------------------------------------------
module ccfp_front import ccfp_pkg::*; #(
  parameter int KEY_CHARS   = KEY_CHARS_DEF,
  parameter int VALUE_CHARS = VALUE_CHARS_DEF,
  localparam int KW = $clog2(KEY_CHARS + 1),
  localparam int VW = $clog2(VALUE_CHARS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  output logic              byte_ready_o,
  input  logic [TEXT_W-1:0] byte_data_i,
  input  logic              byte_last_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output frame_desc_t       q_desc_o,
  output logic              key_we_o,
  output logic [KW:0]       key_waddr_o,
  output logic [TEXT_W-1:0] key_wdata_o,
  output logic              val_we_o,
  output logic [VW:0]       val_waddr_o,
  output logic [TEXT_W-1:0] val_wdata_o
);

  logic [FIELD_W-1:0]    fn_q, fn_a;
  logic [CNT_W-1:0]      cnt_q, cnt_a;
  logic                  tgt_q, tgt_a, tgt_f;
  logic [WORD_COUNT-1:0] mask_q, mask_a, mask_f;
  logic [KW-1:0]         kc_q, kc_a;
  logic [VW-1:0]         vc_q, vc_a;
  logic                  ended_q, ended_a;
  logic                  bank_q;
  logic                  accept;
  logic                  key_wr, val_wr;
  cmd_e                  code;

  assign byte_ready_o = !q_full_i;
  assign accept       = byte_valid_i && byte_ready_o;

  // Effect of one byte on the walker state
  always_comb begin
    fn_a    = fn_q;
    cnt_a   = cnt_q;
    tgt_a   = tgt_q;
    mask_a  = mask_q;
    kc_a    = kc_q;
    vc_a    = vc_q;
    ended_a = ended_q;
    key_wr  = 1'b0;
    val_wr  = 1'b0;
    if (!ended_q) begin
      if (byte_data_i == CHAR_NUL) begin
        ended_a = 1'b1;
      end else if (byte_data_i == CHAR_COMMA) begin
        // close the field in hand
        if (fn_q == FLD_TARGET && cnt_q != CNT_W'(TARGET_LEN)) begin
          tgt_a = 1'b0;
        end
        if (fn_q == FLD_ITEM) begin
          mask_a = mask_q & len_match(cnt_q);
        end
        if (fn_q < FIELD_W'(FIELD_MAX)) begin
          fn_a = fn_q + FIELD_W'(1);
        end
        cnt_a = '0;
      end else begin
        priority if (fn_q == FLD_TARGET) begin
          if (cnt_q >= CNT_W'(TARGET_LEN) || target_char(cnt_q[2:0]) != byte_data_i) begin
            tgt_a = 1'b0;
          end
        end else if (fn_q == FLD_ITEM) begin
          mask_a = mask_q & char_match(cnt_q, byte_data_i);
        end else if (fn_q == FLD_KEY) begin
          if (kc_q < KW'(KEY_CHARS)) begin
            key_wr = 1'b1;
            kc_a   = kc_q + KW'(1);
          end
        end else if (fn_q == FLD_VALUE) begin
          if (vc_q < VW'(VALUE_CHARS)) begin
            val_wr = 1'b1;
            vc_a   = vc_q + VW'(1);
          end
        end else begin
          // fields past the value are skipped
        end
        if (cnt_q != CNT_W'(CHAR_MAX)) begin
          cnt_a = cnt_q + CNT_W'(1);
        end
      end
    end
  end

  // Frame-end close and command decode
  always_comb begin
    tgt_f  = tgt_a;
    mask_f = mask_a;
    if (fn_a == FLD_TARGET && cnt_a != CNT_W'(TARGET_LEN)) begin
      tgt_f = 1'b0;
    end
    if (fn_a == FLD_ITEM) begin
      mask_f = mask_a & len_match(cnt_a);
    end
    code = (fn_a != FLD_TARGET && tgt_f) ? first_code(mask_f) : CMD_NO_MATCH;

    q_desc_o.bank = bank_q;
    if (code != CMD_NO_MATCH) begin
      q_desc_o.status  = STATUS_OK;
      q_desc_o.code    = code;
      q_desc_o.key_len = KEY_LEN_W'(kc_a);
      q_desc_o.val_len = VAL_LEN_W'(vc_a);
    end else begin
      q_desc_o.status  = STATUS_FAIL;
      q_desc_o.code    = CMD_NO_MATCH;
      q_desc_o.key_len = '0;
      q_desc_o.val_len = '0;
    end
  end

  assign q_push_o    = accept && byte_last_i;
  assign key_we_o    = accept && key_wr;
  assign key_waddr_o = {bank_q, kc_q};
  assign key_wdata_o = byte_data_i;
  assign val_we_o    = accept && val_wr;
  assign val_waddr_o = {bank_q, vc_q};
  assign val_wdata_o = byte_data_i;

  // Walker registers; a frame-end beat restarts the walker on the other bank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fn_q    <= FLD_TARGET;
      cnt_q   <= '0;
      tgt_q   <= 1'b1;
      mask_q  <= '1;
      kc_q    <= '0;
      vc_q    <= '0;
      ended_q <= 1'b0;
      bank_q  <= 1'b0;
    end else if (accept) begin
      if (byte_last_i) begin
        fn_q    <= FLD_TARGET;
        cnt_q   <= '0;
        tgt_q   <= 1'b1;
        mask_q  <= '1;
        kc_q    <= '0;
        vc_q    <= '0;
        ended_q <= 1'b0;
        bank_q  <= !bank_q;
      end else begin
        fn_q    <= fn_a;
        cnt_q   <= cnt_a;
        tgt_q   <= tgt_a;
        mask_q  <= mask_a;
        kc_q    <= kc_a;
        vc_q    <= vc_a;
        ended_q <= ended_a;
      end
    end
  end

  // Checks
  a_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fn_q <= FIELD_W'(FIELD_MAX))
    else $error("field number past its limit");

  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kc_q <= KW'(KEY_CHARS))
    else $error("key count past the key buffer");

  a_val_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q <= VW'(VALUE_CHARS))
    else $error("value count past the value buffer");

  a_key_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we_o |-> (fn_q == FLD_KEY && !ended_q))
    else $error("key write outside the key field");

endmodule

@@ sv/ccfp_fifo.sv @@
// ----------------------------------------------------------------------------
// ccfp_fifo
// Two-entry descriptor queue; an entry stays until its frame is drained, so
// the fill level also tells which buffer banks are in use.
// ----------------------------------------------------------------------------
module ccfp_fifo import ccfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  frame_desc_t desc_i,
  input  logic        pop_i,
  output logic        valid_o,
  output logic        full_o,
  output frame_desc_t head_o
);

  frame_desc_t entry_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign head_o  = entry_q[rd_ptr_q];

  // Fill level
  always_comb begin
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

  // Pointers and level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_d;
    end
  end

  // Checks
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("queue level out of range");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

endmodule

@@ sv/ccfp_back.sv @@
// ----------------------------------------------------------------------------
// ccfp_back
// Result sequencer: for each queued frame issues the header, then reads the
// key and value characters out of the frame's buffer bank through the RAM read
// stage and an output register, one beat a cycle unless the output stalls.
// ----------------------------------------------------------------------------
module ccfp_back import ccfp_pkg::*; #(
  parameter int KEY_CHARS   = KEY_CHARS_DEF,
  parameter int VALUE_CHARS = VALUE_CHARS_DEF,
  localparam int KW = $clog2(KEY_CHARS + 1),
  localparam int VW = $clog2(VALUE_CHARS + 1),
  localparam int IW = (KW > VW) ? KW : VW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  frame_desc_t          q_head_i,
  output logic                 q_pop_o,
  output logic                 key_re_o,
  output logic [KW:0]          key_raddr_o,
  input  logic [TEXT_W-1:0]    key_rdata_i,
  output logic                 val_re_o,
  output logic [VW:0]          val_raddr_o,
  input  logic [TEXT_W-1:0]    val_rdata_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [M_TDATA_W-1:0] res_data_o,
  output logic [M_TUSER_W-1:0] res_user_o,
  output logic                 res_last_o
);

  back_state_e       state_q, state_d;
  logic [IW-1:0]     idx_q, idx_d, idx_inc;
  logic              adv, issue;
  logic              key_end, val_end, no_key, no_val;
  out_item_t         item;
  logic              s1_valid_q;
  out_item_t         s1_item_q;
  logic              out_valid_q;
  out_item_t         out_item_q;
  logic [TEXT_W-1:0] out_text_q, s1_text;

  // The pipe moves whenever the output register is free or being taken
  assign adv     = !out_valid_q || res_ready_i;
  assign idx_inc = idx_q + IW'(1);
  assign key_end = (idx_inc == IW'(q_head_i.key_len));
  assign val_end = (idx_inc == IW'(q_head_i.val_len));
  assign no_key  = (q_head_i.key_len == '0);
  assign no_val  = (q_head_i.val_len == '0);

  assign key_raddr_o = {q_head_i.bank, idx_q[KW-1:0]};
  assign val_raddr_o = {q_head_i.bank, idx_q[VW-1:0]};

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_HEADER;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Issue sequencing
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    issue        = 1'b0;
    q_pop_o      = 1'b0;
    key_re_o     = 1'b0;
    val_re_o     = 1'b0;
    item.kind    = KIND_HEADER;
    item.status  = q_head_i.status;
    item.code    = q_head_i.code;
    item.key_len = q_head_i.key_len;
    item.val_len = q_head_i.val_len;
    item.last    = 1'b0;
    unique case (state_q)
      BK_HEADER: begin
        if (adv && q_valid_i) begin
          issue     = 1'b1;
          item.last = no_key && no_val;
          idx_d     = '0;
          if (!no_key) begin
            state_d = BK_KEY;
          end else if (!no_val) begin
            state_d = BK_VALUE;
          end else begin
            q_pop_o = 1'b1;
          end
        end
      end
      BK_KEY: begin
        if (adv) begin
          issue     = 1'b1;
          key_re_o  = 1'b1;
          item.kind = KIND_KEY;
          item.last = key_end && no_val;
          if (key_end) begin
            idx_d = '0;
            if (!no_val) begin
              state_d = BK_VALUE;
            end else begin
              state_d = BK_HEADER;
              q_pop_o = 1'b1;
            end
          end else begin
            idx_d = idx_inc;
          end
        end
      end
      BK_VALUE: begin
        if (adv) begin
          issue     = 1'b1;
          val_re_o  = 1'b1;
          item.kind = KIND_VALUE;
          item.last = val_end;
          if (val_end) begin
            idx_d   = '0;
            state_d = BK_HEADER;
            q_pop_o = 1'b1;
          end else begin
            idx_d = idx_inc;
          end
        end
      end
      default: begin
        state_d = BK_HEADER;
      end
    endcase
  end

  // Character for the beat leaving the read stage
  always_comb begin
    unique case (s1_item_q.kind)
      KIND_KEY:   s1_text = key_rdata_i;
      KIND_VALUE: s1_text = val_rdata_i;
      default:    s1_text = CHAR_NUL;
    endcase
  end

  // Read stage and output register, valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= issue;
      out_valid_q <= s1_valid_q;
    end
  end

  // Read stage and output register, payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_item_q  <= item;
      out_item_q <= s1_item_q;
      out_text_q <= s1_text;
    end
  end

  // Beat packing: status, code, key length, value length, character
  assign res_valid_o = out_valid_q;
  assign res_data_o  = {3'b000, out_text_q, out_item_q.val_len, out_item_q.key_len,
                        out_item_q.code, out_item_q.status};
  assign res_user_o  = out_item_q.kind;
  assign res_last_o  = out_item_q.last;

  // Checks
  a_busy_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BK_HEADER) |-> q_valid_i)
    else $error("sequencer busy without a queued frame");

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (issue && item.last))
    else $error("frame released before its last beat");

  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.status == STATUS_FAIL) |->
      (out_item_q.kind == KIND_HEADER && out_item_q.last &&
       out_item_q.key_len == '0 && out_item_q.val_len == '0))
    else $error("failed frame carries text");

endmodule

@@ sv/csv_command_frame_parser_unit.sv @@
// The header beat of a frame passes the descriptor queue, read stage and output register.
// Throughput: one frame byte per cycle; a frame drains 1 + key + value beats, one a ready cycle.
// The descriptor queue and two buffer banks hold two frames; bytes stall only when both
// wait to drain, the result sequencer, reading one RAM word per ready cycle, being the limit.
// Reset is asynchronous, active low; it clears the walker, queue and sequencer state,
// while the key and value buffers are not cleared and are read only where written.
// ----------------------------------------------------------------------------
// csv_command_frame_parser_unit
// Text command frame parser: splits a byte stream at commas, checks target
// and item words, keeps key and value text and emits header plus text beats.
// ----------------------------------------------------------------------------
module csv_command_frame_parser_unit import ccfp_pkg::*; #(
  parameter int KEY_CHARS   = KEY_CHARS_DEF,
  parameter int VALUE_CHARS = VALUE_CHARS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Frame byte stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [7:0] frame_byte
  input  logic                 s_axis_tlast,  // end_of_frame
  // Result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // [0] parse_status, [3:1] command_code,
                                              // [7:4] key_length, [12:8] value_length,
                                              // [20:13] text_char, [23:21] zero
  output logic [M_TUSER_W-1:0] m_axis_tuser,  // [1:0] result_kind
  output logic                 m_axis_tlast   // last_result
);

  localparam int KW = $clog2(KEY_CHARS + 1);
  localparam int VW = $clog2(VALUE_CHARS + 1);

  logic              q_push, q_pop, q_valid, q_full;
  frame_desc_t       q_desc, q_head;
  logic              key_we, key_re, val_we, val_re;
  logic [KW:0]       key_waddr, key_raddr;
  logic [VW:0]       val_waddr, val_raddr;
  logic [TEXT_W-1:0] key_wdata, key_rdata, val_wdata, val_rdata;

  // Byte walker
  ccfp_front #(
    .KEY_CHARS   (KEY_CHARS),
    .VALUE_CHARS (VALUE_CHARS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_data_i  (s_axis_tdata),
    .byte_last_i  (s_axis_tlast),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_desc_o     (q_desc),
    .key_we_o     (key_we),
    .key_waddr_o  (key_waddr),
    .key_wdata_o  (key_wdata),
    .val_we_o     (val_we),
    .val_waddr_o  (val_waddr),
    .val_wdata_o  (val_wdata)
  );

  // Frame descriptor queue
  ccfp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (q_desc),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .head_o  (q_head)
  );

  // Key buffer, two banks
  ccfp_ram #(
    .WIDTH (TEXT_W),
    .DEPTH (2 ** (KW + 1))
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  // Value buffer, two banks
  ccfp_ram #(
    .WIDTH (TEXT_W),
    .DEPTH (2 ** (VW + 1))
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  // Result sequencer
  ccfp_back #(
    .KEY_CHARS   (KEY_CHARS),
    .VALUE_CHARS (VALUE_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .key_re_o    (key_re),
    .key_raddr_o (key_raddr),
    .key_rdata_i (key_rdata),
    .val_re_o    (val_re),
    .val_raddr_o (val_raddr),
    .val_rdata_i (val_rdata),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata),
    .res_user_o  (m_axis_tuser),
    .res_last_o  (m_axis_tlast)
  );

endmodule
